// ===== rtl/core/srfm_pkg.sv =====
// Shared types, constants and helpers for the first-match stream substitution block.
`default_nettype none

package srfm_pkg;

    localparam int MAX_PATTERN  = 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int LEN_W        = 4;
    localparam int IDX_W        = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_BYTES     = 2'd0,
        REG_PATTERN_LENGTH    = 2'd1,
        REG_REPLACEMENT_BYTES = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern;
        logic [LEN_W-1:0]      pattern_len;
        logic [CFG_DATA_W-1:0] replacement;
        logic [LEN_W-1:0]      replacement_len;
    } cfg_t;

    // One item's work as segments of a flat result index: replacement before e0,
    // released pattern prefix (or the item's byte at its end) before e1,
    // replacement before e2, held pattern prefix before total.
    typedef struct packed {
        logic [7:0]       data;
        logic             data_in_a;
        logic [LEN_W-1:0] a_cnt;
        logic [IDX_W-1:0] e0;
        logic [IDX_W-1:0] e1;
        logic [IDX_W-1:0] e2;
        logic [IDX_W-1:0] total;
        logic             line_last;
    } job_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : v;
    endfunction

    function automatic logic [7:0] byte_at(input logic [CFG_DATA_W-1:0] w,
                                           input logic [2:0] i);
        return w[{i, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stream_replace_first_match.sv =====
// Top level of the first-match stream substitution block.
// The block copies a line of bytes to the output and replaces the leftmost
// occurrence of the configured pattern with the configured replacement. An input
// item is taken in every cycle while the four-entry job queue has room; the
// result sequencer then drives one result item per cycle while the output is not
// stalled, and an item causes up to nine results, or one end marker. The first
// result of an item passes through the job queue and then the output register.
// The user must write configuration only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module stream_replace_first_match (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [srfm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [srfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // text_byte
    input  wire logic                            s_tuser,   // byte_present
    input  wire logic                            s_tlast,   // line_end
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // out_byte
    output logic [1:0]                           m_tuser,   // out_present, run_last
    output logic                                 m_tlast    // out_line_last
);
    import srfm_pkg::*;

    cfg_t cfg_reg;
    job_t push_job, head;
    logic push, pop, q_full, q_empty;
    logic out_present, out_run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_PATTERN_BYTES:      cfg_reg.pattern         <= cfg_wdata;
                REG_PATTERN_LENGTH:     cfg_reg.pattern_len     <= cfg_wdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement     <= cfg_wdata;
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_len <= cfg_wdata[LEN_W-1:0];
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    srfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    srfm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    srfm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head          (head),
        .q_empty       (q_empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_present   (out_present),
        .out_line_last (m_tlast),
        .out_run_last  (out_run_last)
    );

    assign m_tuser = {out_run_last, out_present};

endmodule

`default_nettype wire

// ===== rtl/core/srfm_front.sv =====
// Front end: accepts items, tracks the partial match and emits a job for each item that has results or ends a line.
`default_nettype none

module srfm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire srfm_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_present,
    input  wire logic           in_last,
    input  wire logic           q_full,
    output logic                push,
    output srfm_pkg::job_t      push_job
);
    import srfm_pkg::*;

    logic [LEN_W-1:0]       matched_reg, matched_next;
    logic                   done_reg, done_next;
    logic                   start_reg, start_next;
    logic [LEN_W-1:0]       len, rlen, m, m_new, m_keep;
    logic [LEN_W-1:0]       a_cnt, lead_cnt, mid_cnt, b_cnt;
    logic [7:0]             pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pe [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;
    logic [LEN_W-1:0]       pos;
    logic                   accept, matching, lead, full, data_in_a, done_keep;
    logic [IDX_W-1:0]       e0, e1, e2, total;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        len  = clamp_len(cfg.pattern_len);
        rlen = clamp_len(cfg.replacement_len);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat[i] = byte_at(cfg.pattern, 3'(i));
        end
        for (int a = 0; a < MAX_PATTERN; a++)
        begin
            for (int b = 0; b < MAX_PATTERN; b++)
            begin
                pe[a][b] = (pat[a] == pat[b]);
            end
        end

        if (len == '0)
            m = '0;
        else if (matched_reg > len - LEN_W'(1))
            m = len - LEN_W'(1);
        else
            m = matched_reg;

        // A prefix of length j survives if it is a suffix of the held bytes plus this byte.
        pos = '0;
        for (int j = 1; j <= MAX_PATTERN; j++)
        begin
            hit[j-1] = (LEN_W'(j) <= m + LEN_W'(1)) && (LEN_W'(j) <= len)
                       && (pat[j-1] == in_byte);
            for (int t = 0; t < j - 1; t++)
            begin
                pos = m + LEN_W'(1) - LEN_W'(j) + LEN_W'(t);
                hit[j-1] = hit[j-1] & pe[t][pos[2:0]];
            end
        end
        m_new = '0;
        for (int j = 1; j <= MAX_PATTERN; j++)
        begin
            if (hit[j-1])
                m_new = LEN_W'(j);
        end

        lead     = (len == '0) && start_reg && !done_reg;
        lead_cnt = lead ? rlen : '0;
        matching = (len != '0) && !done_reg && in_present;
        full     = matching && (m_new == len);

        if (matching)
        begin
            a_cnt     = m + LEN_W'(1) - m_new;
            data_in_a = (m_new == '0);
            mid_cnt   = full ? rlen : '0;
            m_keep    = full ? '0 : m_new;
            done_keep = full;
        end
        else
        begin
            a_cnt     = in_present ? LEN_W'(1) : '0;
            data_in_a = in_present;
            mid_cnt   = '0;
            m_keep    = m;
            done_keep = done_reg || lead;
        end
        b_cnt = in_last ? m_keep : '0;

        e0    = IDX_W'(lead_cnt);
        e1    = e0 + IDX_W'(a_cnt);
        e2    = e1 + IDX_W'(mid_cnt);
        total = e2 + IDX_W'(b_cnt);

        push_job.data      = in_byte;
        push_job.data_in_a = data_in_a;
        push_job.a_cnt     = a_cnt;
        push_job.e0        = e0;
        push_job.e1        = e1;
        push_job.e2        = e2;
        push_job.total     = total;
        push_job.line_last = in_last;
        push = accept && ((total != '0) || in_last);

        matched_next = matched_reg;
        done_next    = done_reg;
        start_next   = start_reg;
        if (accept)
        begin
            if (in_last)
            begin
                matched_next = '0;
                done_next    = 1'b0;
                start_next   = 1'b1;
            end
            else
            begin
                matched_next = m_keep;
                done_next    = done_keep;
                start_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= '0;
            done_reg    <= 1'b0;
            start_reg   <= 1'b1;
        end
        else
        begin
            matched_reg <= matched_next;
            done_reg    <= done_next;
            start_reg   <= start_next;
        end
    end

    a_matched_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg < LEN_W'(MAX_PATTERN))
        else $error("held prefix count reached the pattern size");

    a_done_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !start_reg)
        else $error("replacement marked done at the start of a line");

endmodule

`default_nettype wire

// ===== rtl/core/srfm_queue.sv =====
// Short job queue between the front end and the result sequencer.
`default_nettype none

module srfm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire srfm_pkg::job_t push_job,
    input  wire logic           pop,
    output srfm_pkg::job_t      head,
    output logic                full,
    output logic                empty
);
    import srfm_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_no_overflow_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push |-> !full) and (pop |-> !empty))
        else $error("queue written when full or read when empty");

endmodule

`default_nettype wire

// ===== rtl/core/srfm_back.sv =====
// Back end: expands each job into result items, one per cycle unless the output stalls, into an output register.
`default_nettype none

module srfm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire srfm_pkg::cfg_t cfg,
    input  wire srfm_pkg::job_t head,
    input  wire logic           q_empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_present,
    output logic                out_line_last,
    output logic                out_run_last
);
    import srfm_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_present_reg, out_line_last_reg, out_run_last_reg;
    logic [IDX_W-1:0] k;
    logic [7:0]       sel_byte;
    logic             sel_present, job_end, advance, fire;

    always_comb
    begin
        job_end = (head.total == '0) || (idx_reg == head.total - IDX_W'(1));
        advance = !out_valid_reg || out_ready;
        fire    = advance && !q_empty;
        pop     = fire && job_end;

        k           = '0;
        sel_present = 1'b1;
        if (head.total == '0)
        begin
            sel_byte    = '0;
            sel_present = 1'b0;
        end
        else if (idx_reg < head.e0)
        begin
            sel_byte = byte_at(cfg.replacement, idx_reg[2:0]);
        end
        else if (idx_reg < head.e1)
        begin
            k = idx_reg - head.e0;
            if (head.data_in_a && (k == IDX_W'(head.a_cnt) - IDX_W'(1)))
                sel_byte = head.data;
            else
                sel_byte = byte_at(cfg.pattern, k[2:0]);
        end
        else if (idx_reg < head.e2)
        begin
            k        = idx_reg - head.e1;
            sel_byte = byte_at(cfg.replacement, k[2:0]);
        end
        else
        begin
            k        = idx_reg - head.e2;
            sel_byte = byte_at(cfg.pattern, k[2:0]);
        end

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            idx_next       = job_end ? '0 : idx_reg + IDX_W'(1);
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg      <= sel_byte;
            out_present_reg   <= sel_present;
            out_line_last_reg <= job_end && head.line_last;
            out_run_last_reg  <= job_end;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_present   = out_present_reg;
    assign out_line_last = out_line_last_reg;
    assign out_run_last  = out_run_last_reg;

    a_index_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> ((head.total == '0 && idx_reg == '0) || (idx_reg < head.total)))
        else $error("result index outside the current job");

    a_index_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (idx_reg == '0))
        else $error("result index left over with no job pending");

endmodule

`default_nettype wire
